FILE: rtl/ordered_list_insert_delete_unit_defines.svh
// Assertion macros used by the ordered list top level.
`ifndef ORDERED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define OLID_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset only.
`define OLID_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/olid_pkg.sv
// Types, codes and sizes shared by the ordered list unit and its cells.
package olid_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int CMP_W    = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    // request types
    localparam logic [1:0] REQ_INS  = 2'd0;
    localparam logic [1:0] REQ_DEL  = 2'd1;
    localparam logic [1:0] REQ_DUMP = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BADPOS   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [31:0] value;
        logic [POS_W-1:0]  position;
    } t_request;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] item_value;
        logic               item_valid;
        logic               last;
    } t_result;

    typedef enum logic [2:0] {
        C_HOLD,
        C_INS,
        C_CMP,
        C_DEL,
        C_ROT
    } t_cell_op;

    // broadcast to every cell
    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] value;
        logic [LEN_W-1:0]   sel;   // insert slot, or last live slot on rotate
        logic [LEN_W-1:0]   len;
    } t_cell_cmd;

endpackage

FILE: rtl/olid_cell.sv
// One list slot: holds an entry, shifts up/down, matches, rotates.
module olid_cell
    import olid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [IDX_W-1:0]   i_idx,
    input  t_cell_cmd          i_cmd,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    input  logic signed [31:0] i_head,
    input  logic               i_hit,
    output logic signed [31:0] o_data,
    output logic               o_hit
);

    logic signed [31:0] r_data;
    logic               r_hit;
    logic [LEN_W-1:0]   idx_l;

    assign idx_l  = LEN_W'(i_idx);
    assign o_data = r_data;
    assign o_hit  = i_hit | r_hit;   // a hit at or before this slot

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            C_INS: begin
                if (idx_l == i_cmd.sel) begin
                    r_data <= i_cmd.value;
                end else if (idx_l > i_cmd.sel) begin
                    r_data <= i_left;
                end
            end
            C_DEL: begin
                if (o_hit) begin
                    r_data <= i_right;
                end
            end
            C_ROT: begin
                if (idx_l == i_cmd.sel) begin
                    r_data <= i_head;
                end else if (idx_l < i_cmd.sel) begin
                    r_data <= i_right;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.op == C_CMP) begin
            r_hit <= (r_data == i_cmd.value) && (idx_l < i_cmd.len);
        end
    end

endmodule

FILE: rtl/ordered_list_insert_delete_unit.sv
// Top level: ordered list of signed 32-bit values built as a row of cells.
//
//  channel   | handshake          | payload          | notes
//  ----------+--------------------+------------------+----------------------------
//  request   | start, busy        | i_request        | taken when start & !busy
//  result    | o_strobe           | o_result         | one cycle each, no backpress
//
// Work per request: insert in the S_INS state; delete a match pass (S_CMP) then
// a shift pass (S_DEL), the first-hit prefix running down the cell row, with an
// empty list answered from the match pass; dump one rotation of the row per entry,
// head cell emitted; an empty dump answers with an empty status.
// busy is high from the cycle after a request is taken until its final result
// is on the ports; a new request may be taken in the cycle that result shows.
// Reset clears the length and control only; entries stay unknown until written.
// Request type 3 is dropped on acceptance without a result.
module ordered_list_insert_delete_unit
    import olid_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_request,
    output logic     busy,
    output logic     o_strobe,
    output t_result  o_result
);

`include "ordered_list_insert_delete_unit_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_CMP,
        S_DEL,
        S_DUMP
    } t_state;

    t_state             r_state;
    t_request           r_req;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_cnt;
    logic               r_strobe;
    t_result            r_result;

    t_cell_cmd          cmd;
    logic signed [31:0] cell_data [CAPACITY];
    logic               hit_chain [CAPACITY+1];

    // insert position, full, match and last-dump checks
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   len_p1;
    logic               pos_bad;
    logic               is_full;
    logic               found;
    logic               dump_last;

    assign pos_ext   = CMP_W'(r_req.position);
    assign len_p1    = CMP_W'(r_len) + CMP_W'(1);
    assign pos_bad   = (pos_ext == '0) || (pos_ext > len_p1);
    assign is_full   = (r_len >= LEN_W'(CAPACITY));
    assign found     = hit_chain[CAPACITY];
    assign dump_last = (r_cnt == r_len - LEN_W'(1));

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // command broadcast to the cell row
    always_comb begin
        cmd.op    = C_HOLD;
        cmd.value = r_req.value;
        cmd.sel   = LEN_W'(pos_ext - CMP_W'(1));
        cmd.len   = r_len;
        case (r_state)
            S_INS: begin
                if (!pos_bad && !is_full) begin
                    cmd.op = C_INS;
                end
            end
            S_CMP: begin
                cmd.op = C_CMP;
            end
            S_DEL: begin
                if (found) begin
                    cmd.op = C_DEL;
                end
            end
            S_DUMP: begin
                cmd.sel = r_len - LEN_W'(1);
                if (r_len != '0) begin
                    cmd.op = C_ROT;
                end
            end
            default: begin
            end
        endcase
    end

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] left_d;
        logic signed [31:0] right_d;

        if (g == 0) begin : g_first
            assign left_d = r_req.value;
        end else begin : g_mid_l
            assign left_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign right_d = cell_data[g];
        end else begin : g_mid_r
            assign right_d = cell_data[g+1];
        end

        olid_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (IDX_W'(g)),
            .i_cmd   (cmd),
            .i_left  (left_d),
            .i_right (right_d),
            .i_head  (cell_data[0]),
            .i_hit   (hit_chain[g]),
            .o_data  (cell_data[g]),
            .o_hit   (hit_chain[g+1])
        );
    end

    // request sequencer, length and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req <= i_request;
                        r_cnt <= '0;
                        case (i_request.req_type)
                            REQ_INS:  r_state <= S_INS;
                            REQ_DEL:  r_state <= S_CMP;
                            REQ_DUMP: r_state <= S_DUMP;
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_INS: begin
                    r_strobe            <= 1'b1;
                    r_result.item_value <= '0;
                    r_result.item_valid <= 1'b0;
                    r_result.last       <= 1'b1;
                    if (pos_bad) begin
                        r_result.status <= ST_BADPOS;
                    end else if (is_full) begin
                        r_result.status <= ST_FULL;
                    end else begin
                        r_result.status <= ST_OK;
                        r_len           <= r_len + LEN_W'(1);
                    end
                    r_state <= S_IDLE;
                end
                S_CMP: begin
                    if (r_len == '0) begin
                        r_strobe            <= 1'b1;
                        r_result.status     <= ST_EMPTY;
                        r_result.item_value <= '0;
                        r_result.item_valid <= 1'b0;
                        r_result.last       <= 1'b1;
                        r_state             <= S_IDLE;
                    end else begin
                        r_state <= S_DEL;
                    end
                end
                S_DEL: begin
                    r_strobe            <= 1'b1;
                    r_result.item_value <= '0;
                    r_result.item_valid <= 1'b0;
                    r_result.last       <= 1'b1;
                    if (found) begin
                        r_result.status <= ST_OK;
                        r_len           <= r_len - LEN_W'(1);
                    end else begin
                        r_result.status <= ST_NOTFOUND;
                    end
                    r_state <= S_IDLE;
                end
                S_DUMP: begin
                    r_strobe <= 1'b1;
                    if (r_len == '0) begin
                        r_result.status     <= ST_EMPTY;
                        r_result.item_value <= '0;
                        r_result.item_valid <= 1'b0;
                        r_result.last       <= 1'b1;
                        r_state             <= S_IDLE;
                    end else begin
                        // head cell is the next entry in order
                        r_result.status     <= ST_OK;
                        r_result.item_value <= cell_data[0];
                        r_result.item_valid <= 1'b1;
                        r_result.last       <= dump_last;
                        r_cnt               <= r_cnt + LEN_W'(1);
                        if (dump_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `OLID_ASSERT_IMP(a_len_bound, 1'b1, r_len <= LEN_W'(CAPACITY),
        "list length above capacity")
    `OLID_ASSERT_IMP(a_strobe_from_work, r_strobe, $past(r_state) != S_IDLE,
        "result strobe without a request in progress")
    `OLID_ASSERT_IMP(a_len_moves_on_ok, r_len != $past(r_len),
        r_strobe && (r_result.status == ST_OK) && !r_result.item_valid,
        "length changed without an ok insert or delete")
    `OLID_ASSERT_NXT(a_dump_leaves_len, r_state == S_DUMP, r_len == $past(r_len),
        "dump altered the list length")

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the ordered list insert/delete unit.
module tb_top
    import olid_pkg::*;
();

    localparam int HALF_PERIOD = 4;
    localparam int IDLE_LIMIT  = 2000;              // cycles with no request and no result
    localparam int TAIL_CYCLES = 2 * CAPACITY + 8;  // settle time after the last result
    localparam int MAX_GAP     = 40;
    localparam int REPORT_MAX  = 10;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic     i_clk     = 1'b0;
    logic     i_rst_n   = 1'b0;
    logic     start     = 1'b0;
    t_request i_request = '0;
    logic     busy;
    logic     o_strobe;
    t_result  o_result;

    // shadow copy of the list, updated in request order
    logic signed [31:0] list_model [CAPACITY];
    int                 list_len        = 0;
    t_result            pending_results [$];
    int unsigned        mismatch_count  = 0;
    int unsigned        sender_idle_pct = 0;

    ordered_list_insert_delete_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (i_request),
        .busy      (busy),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_result pack_result(logic [2:0] st, logic signed [31:0] v,
                                            logic vld, logic fin);
        t_result r;
        r.status     = st;
        r.item_value = v;
        r.item_valid = vld;
        r.last       = fin;
        return r;
    endfunction

    // Apply one accepted request to the shadow list and queue what it yields.
    function automatic void predict_list_results(t_request req);
        int pos;
        int hit;
        int i;
        pos = int'(req.position);
        hit = -1;
        case (req.req_type)
            REQ_INS: begin
                // position check wins over the full check
                if (pos < 1 || pos > list_len + 1) begin
                    pending_results.push_back(pack_result(ST_BADPOS, '0, 1'b0, 1'b1));
                end else if (list_len >= CAPACITY) begin
                    pending_results.push_back(pack_result(ST_FULL, '0, 1'b0, 1'b1));
                end else begin
                    for (i = list_len; i > pos - 1; i--)
                        list_model[i] = list_model[i-1];
                    list_model[pos-1] = req.value;
                    list_len++;
                    pending_results.push_back(pack_result(ST_OK, '0, 1'b0, 1'b1));
                end
            end
            REQ_DEL: begin
                if (list_len == 0) begin
                    pending_results.push_back(pack_result(ST_EMPTY, '0, 1'b0, 1'b1));
                end else begin
                    for (i = 0; i < list_len; i++)
                        if (hit < 0 && list_model[i] == req.value) hit = i;
                    if (hit < 0) begin
                        pending_results.push_back(pack_result(ST_NOTFOUND, '0, 1'b0, 1'b1));
                    end else begin
                        for (i = hit; i < list_len - 1; i++)
                            list_model[i] = list_model[i+1];
                        list_len--;
                        pending_results.push_back(pack_result(ST_OK, '0, 1'b0, 1'b1));
                    end
                end
            end
            REQ_DUMP: begin
                if (list_len == 0) begin
                    pending_results.push_back(pack_result(ST_EMPTY, '0, 1'b0, 1'b1));
                end else begin
                    for (i = 0; i < list_len; i++)
                        pending_results.push_back(pack_result(ST_OK, list_model[i], 1'b1,
                                                              i == list_len - 1));
                end
            end
            default: begin
                // unused type: dropped, no result
            end
        endcase
    endfunction

    function automatic t_request make_request(logic [1:0] kind, logic signed [31:0] v,
                                              logic [POS_W-1:0] pos);
        t_request r;
        r.req_type = kind;
        r.value    = v;
        r.position = pos;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that took the request.
    // start stays high afterwards so back-to-back requests need no toggle.
    task automatic send_request(t_request req);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_request <= req;
        do @(posedge i_clk); while (busy);
        predict_list_results(req);
    endtask

    // Hold off the sender until every queued result has shown up.
    task automatic wait_results_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Random request; ins_pct/del_pct steer the list length up or down.
    function automatic t_request pick_request(int unsigned ins_pct, int unsigned del_pct);
        t_request    r;
        int unsigned roll;
        int unsigned vsel;
        roll       = $urandom_range(99);
        vsel       = $urandom_range(19);
        r.position = POS_W'($urandom_range(31));
        case (vsel)
            0:       r.value = 32'sh8000_0000;
            1:       r.value = 32'sh7fff_ffff;
            2:       r.value = '0;
            3, 4, 5: r.value = $urandom_range(7);   // small pool, forces duplicates
            default: r.value = $urandom;
        endcase
        if (roll < ins_pct) begin
            r.req_type = REQ_INS;
            if ($urandom_range(9) < 8) r.position = POS_W'($urandom_range(list_len + 1, 1));
        end else if (roll < ins_pct + del_pct) begin
            r.req_type = REQ_DEL;
            if (list_len > 0 && $urandom_range(9) < 7)
                r.value = list_model[$urandom_range(list_len - 1)];
        end else if (roll < 96) begin
            r.req_type = REQ_DUMP;
        end else begin
            r.req_type = REQ_UNUSED;
        end
        return r;
    endfunction

    task automatic test_empty_list();
        send_request(make_request(REQ_DUMP, '0, 5'd0));
        send_request(make_request(REQ_DEL, 32'sd5, 5'd1));
        send_request(make_request(REQ_UNUSED, 32'shffff_ffff, 5'd31));
    endtask

    task automatic test_insert_positions();
        send_request(make_request(REQ_INS, 32'sd7, 5'd0));            // position zero
        send_request(make_request(REQ_INS, 32'sh8000_0000, 5'd1));    // into empty list
        send_request(make_request(REQ_INS, 32'sd9, 5'd3));            // past length+1
        send_request(make_request(REQ_INS, 32'sh7fff_ffff, 5'd2));    // append
        send_request(make_request(REQ_INS, '0, 5'd1));                // new head
        send_request(make_request(REQ_INS, 32'sd11, 5'd31));          // top of field
    endtask

    task automatic test_full_list();
        t_request req;
        while (list_len < CAPACITY) begin
            req = make_request(REQ_INS, $urandom_range(3), 5'($urandom_range(list_len + 1, 1)));
            send_request(req);
        end
        send_request(make_request(REQ_INS, 32'sd1, 5'(CAPACITY + 1)));  // valid slot, no room
        send_request(make_request(REQ_INS, 32'sd1, 5'd0));              // bad slot beats full
        send_request(make_request(REQ_DUMP, '0, 5'd0));
    endtask

    task automatic test_delete_cases();
        send_request(make_request(REQ_DEL, 32'sh1234_5678, 5'd0));    // absent
        send_request(make_request(REQ_DEL, 32'sh8000_0000, 5'd0));    // entry in the list
        send_request(make_request(REQ_DEL, list_model[list_len-1], 5'd0));  // first of dups
        send_request(make_request(REQ_DUMP, '0, 5'd0));
    endtask

    task automatic test_random_traffic(int unsigned n_items, int unsigned idle_pct,
                                       int unsigned ins_pct, int unsigned del_pct);
        t_request    req;
        int unsigned sent;
        sent            = 0;
        sender_idle_pct = idle_pct;
        while (sent < n_items) begin
            req = pick_request(ins_pct, del_pct);
            send_request(req);
            if (req.req_type != REQ_UNUSED) sent++;
            if ($urandom_range(39) == 0) wait_results_drained();
        end
    endtask

    // Every strobe is compared against the oldest queued result.
    always @(posedge i_clk) begin : result_check
        t_result exp_res;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: status %0d value %0d valid %0b last %0b",
                             o_result.status, o_result.item_value,
                             o_result.item_valid, o_result.last);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_result.status !== exp_res.status ||
                    o_result.item_value !== exp_res.item_value ||
                    o_result.item_valid !== exp_res.item_valid ||
                    o_result.last !== exp_res.last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result mismatch: expected status %0d value %0d valid %0b ",
                                 exp_res.status, exp_res.item_value, exp_res.item_valid,
                                 "last %0b, got status %0d value %0d valid %0b last %0b",
                                 exp_res.last, o_result.status, o_result.item_value,
                                 o_result.item_valid, o_result.last);
                end
            end
        end
    end

    // Stall guard: any accepted request or result resets the count.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("ordered_list_insert_delete_unit regression: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 9;
        test_empty_list();
        test_insert_positions();
        test_full_list();
        test_delete_cases();
        wait_results_drained();

        test_random_traffic(60, 9, 60, 25);
        wait_results_drained();
        test_random_traffic(60, 86, 30, 55);
        wait_results_drained();
        test_random_traffic(60, 0, 45, 40);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ordered_list_insert_delete_unit regression: pass");
        else
            $display("ordered_list_insert_delete_unit regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/olid_pkg.sv
rtl/olid_cell.sv
rtl/ordered_list_insert_delete_unit.sv
tb/sv/tb_top.sv
